// ----- rtl/cluv_pkg.sv -----
// Shared widths, constants, sideband types and saturation helpers for the CIELUV to RGB converter.
// No dependencies; the top level and cluv_matrix import this package.
`default_nettype none

package cluv_pkg;

    localparam int L_W     = 15;
    localparam int C_W     = 17;
    localparam int CH_W    = 12;
    localparam int UV_W    = 24;
    localparam int Y_W     = 22;
    localparam int T_W     = 21;
    localparam int W_W     = 29;
    localparam int XZ_W    = 32;
    localparam int COEF_W  = 23;
    localparam int PROD_W  = 55;
    localparam int SUM_W   = 58;

    // First divider bank: chromaticities
    localparam int UVD_NUM_W = 37;
    localparam int UVD_DEN_W = 19;
    localparam int D1_QUO_W  = 24;

    // Second divider bank: X and Z
    localparam int XZD_NUM_W = 50;
    localparam int XZD_DEN_W = 25;
    localparam int D2_QUO_W  = 31;

    // Luminance seed by reciprocal multiplication. L * 40960 / 9033 is L times the rounded-up
    // reciprocal shifted down by 25, exact for L up to 2048. (L + 4096) * 1024 / 29 is
    // (L + 4096) times the rounded-up reciprocal shifted down by 24, exact for every L.
    localparam int L_LIN_W  = 12;
    localparam int YLP_W    = 40;
    localparam int YCP_W    = 46;
    localparam int Y_LIN_SH  = 25;
    localparam int Y_CUBE_SH = 24;
    localparam logic [27:0]  Y_LIN_RECIP  = 28'd152152058;
    localparam logic [29:0]  Y_CUBE_RECIP = 30'd592409283;
    localparam logic [L_W:0] L_CUBE_OFS   = 16'd4096;

    localparam logic signed [25:0] UN_Q20 = 26'sd220753;
    localparam logic signed [25:0] VN_Q20 = 26'sd496694;
    localparam logic signed [UV_W-1:0] UV_MAX = 24'sh7FFFFF;
    localparam logic signed [UV_W-1:0] UV_MIN = 24'sh800000;
    localparam logic signed [XZ_W-1:0] XZ_MAX = 32'sh7FFFFFFF;
    localparam logic signed [XZ_W-1:0] XZ_MIN = 32'sh80000000;
    localparam logic signed [W_W-1:0]  W_BIAS = 29'sd12582912;
    localparam logic [L_W-1:0]         L_LIN_MAX  = 15'd2048;
    localparam logic [CH_W-1:0]        CH_MAX = 12'hFFF;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t MAT_Q20 [3][3] = '{
        '{ 23'sd3212017, -23'sd1461007,  -23'sd498915},
        '{-23'sd1016325,  23'sd1967093,    23'sd43574},
        '{   23'sd71168,   -23'sd239950,  23'sd1121191}
    };

    typedef struct packed {
        logic [T_W-1:0] t;
        logic           lin;
        logic           zero;
        logic           neg;
        logic           ovf;
    } uside_t;

    typedef struct packed {
        logic neg;
        logic ovf;
    } vside_t;

    typedef struct packed {
        logic [Y_W-1:0] y;
        logic           neg;
        logic           ovf;
        logic           zero;
        logic           degen;
    } xside_t;

    // Signed chromaticity from a magnitude quotient, white-point offset and 24-bit clamp.
    function automatic logic signed [UV_W-1:0] sat_uv(input logic [D1_QUO_W-1:0] q,
                                                      input logic neg, input logic ovf,
                                                      input logic signed [25:0] bias);
        logic signed [25:0] mag;
        logic signed [25:0] s;
        mag = $signed({2'b00, q});
        s   = (neg ? -mag : mag) + bias;
        if (ovf) begin
            return neg ? UV_MIN : UV_MAX;
        end else if (s > 26'sd8388607) begin
            return UV_MAX;
        end else if (s < -26'sd8388608) begin
            return UV_MIN;
        end else begin
            return s[UV_W-1:0];
        end
    endfunction

    // Signed X or Z from a magnitude quotient with a 32-bit clamp.
    function automatic logic signed [XZ_W-1:0] sat_xz(input logic [D2_QUO_W-1:0] q,
                                                      input logic neg, input logic ovf);
        logic signed [XZ_W-1:0] mag;
        mag = $signed({1'b0, q});
        if (ovf) begin
            return neg ? XZ_MIN : XZ_MAX;
        end else begin
            return neg ? -mag : mag;
        end
    endfunction

    // Channel sum in Q.40 to saturated Q0.12.
    function automatic logic [CH_W-1:0] to_q12(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] rnd;
        logic [29:0]             v;
        rnd = (sum + 58'sd134217728) >>> 28;
        v   = rnd[29:0];
        if (sum <= 0) begin
            return '0;
        end else if (v > 30'(CH_MAX)) begin
            return CH_MAX;
        end else begin
            return v[CH_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cieluv_to_rgb_converter.sv -----
// Top level of the CIELUV to linear RGB converter.
// Depends on cluv_pkg, cluv_div_pipe and cluv_matrix.
//
// The converter takes one CIELUV pixel per clock (L* in unsigned Q7.8, u* and v* in signed
// Q8.8) and returns linear red, green and blue in Q0.12, each saturated to the range 0 to 1,
// where 1.0 reads as 4095. A new item may enter in every cycle unless the result port
// stalls, so the sustained rate is one pixel per clock. Most of the pipeline is the two
// banks of bit-serial pipelined dividers: 24 stages for the chromaticities u' and v', and
// 31 stages for X and Z. The luminance seed is formed by a reciprocal multiplication and
// travels alongside the first bank. The rest is one input register, four stages that form
// the clamped chromaticities and the cube for Y, three matrix stages and the result register.
// A pixel of zero lightness comes out black with degenerate clear; a pixel whose v' is not
// positive comes out black with degenerate set. The whole pipeline advances together: when
// the result register holds an item that has not been taken, every stage holds and s_ready
// is low, so nothing is lost or repeated. There is no configuration and no state beyond the
// pipeline itself.
`default_nettype none

module cieluv_to_rgb_converter
    import cluv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [L_W-1:0]        s_lightness,
    input  wire logic signed [C_W-1:0] s_chroma_u,
    input  wire logic signed [C_W-1:0] s_chroma_v,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CH_W-1:0]            m_red,
    output logic [CH_W-1:0]            m_green,
    output logic [CH_W-1:0]            m_blue,
    output logic                       m_degenerate
);

    // One enable for every stage: the pipeline moves unless a result is stuck at the port.
    logic adv;
    assign adv     = ~m_valid | m_ready;
    assign s_ready = adv;

    // Input register.
    logic                  in_vld_reg;
    logic [L_W-1:0]        l_reg;
    logic signed [C_W-1:0] u_reg, v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_valid;
        end
        if (adv) begin
            l_reg <= s_lightness;
            u_reg <= s_chroma_u;
            v_reg <= s_chroma_v;
        end
    end

    // Dividend preparation for the first divider bank. The chroma quotients are taken on
    // magnitudes and signed afterwards, which truncates towards zero. A quotient that would
    // reach 2^24 saturates whatever the white-point offset, so only 24 bits are developed.
    logic [C_W-1:0]       u_mag, v_mag;
    logic [UVD_DEN_W-1:0] den13;
    logic [UVD_DEN_W-1:0] l_ext;
    logic                 l_small;
    logic [L_W:0]         l_ofs;
    logic [YLP_W-1:0]     y_lin_prod;
    logic [YCP_W-1:0]     y_cube_prod;
    uside_t               u_side_in, u_side_out;
    vside_t               v_side_in, v_side_out;

    assign u_mag   = u_reg[C_W-1] ? C_W'(-u_reg) : C_W'(u_reg);
    assign v_mag   = v_reg[C_W-1] ? C_W'(-v_reg) : C_W'(v_reg);
    assign l_ext   = UVD_DEN_W'(l_reg);
    assign den13   = (l_ext << 3) + (l_ext << 2) + l_ext;
    assign l_small = l_reg <= L_LIN_MAX;

    // Low lightness: Y = L * 40960 / 9033. Otherwise the cube root seed
    // t = (L + 4096) * 2^20 / 29696, which is (L + 4096) * 2^10 / 29. Both quotients come
    // from a multiplication by a rounded-up reciprocal, and the seed rides in the sideband
    // of the u' divider so that it meets the chromaticities at its output.
    assign l_ofs       = (L_W+1)'(l_reg) + L_CUBE_OFS;
    assign y_lin_prod  = YLP_W'(l_reg[L_LIN_W-1:0]) * YLP_W'(Y_LIN_RECIP);
    assign y_cube_prod = YCP_W'(l_ofs) * YCP_W'(Y_CUBE_RECIP);

    assign u_side_in.t    = l_small ? T_W'(y_lin_prod >> Y_LIN_SH)
                                    : T_W'(y_cube_prod >> Y_CUBE_SH);
    assign u_side_in.lin  = l_small;
    assign u_side_in.zero = l_reg == '0;
    assign u_side_in.neg  = u_reg[C_W-1];
    assign u_side_in.ovf  = UVD_DEN_W'(u_mag[C_W-1:4]) >= den13;
    assign v_side_in.neg  = v_reg[C_W-1];
    assign v_side_in.ovf  = UVD_DEN_W'(v_mag[C_W-1:4]) >= den13;

    logic                d1_vld;
    logic [D1_QUO_W-1:0] uq, vq;

    cluv_div_pipe #(
        .NUM_W (UVD_NUM_W),
        .DEN_W (UVD_DEN_W),
        .QUO_W (D1_QUO_W),
        .SIDE_W($bits(uside_t))
    ) u_div_u (
        .aclk   (aclk),
        .aresetn(aresetn),
        .adv    (adv),
        .vld_i  (in_vld_reg),
        .num_i  ({u_mag, 20'd0}),
        .den_i  (den13),
        .side_i (u_side_in),
        .vld_o  (d1_vld),
        .quo_o  (uq),
        .side_o (u_side_out)
    );

    cluv_div_pipe #(
        .NUM_W (UVD_NUM_W),
        .DEN_W (UVD_DEN_W),
        .QUO_W (D1_QUO_W),
        .SIDE_W($bits(vside_t))
    ) u_div_v (
        .aclk   (aclk),
        .aresetn(aresetn),
        .adv    (adv),
        .vld_i  (in_vld_reg),
        .num_i  ({v_mag, 20'd0}),
        .den_i  (den13),
        .side_i (v_side_in),
        .vld_o  (),
        .quo_o  (vq),
        .side_o (v_side_out)
    );

    // Stage C1: clamped u' and v', the degenerate test and the square of the seed.
    logic signed [UV_W-1:0] up_c;
    logic signed [UV_W-1:0] vp_c;

    assign up_c = sat_uv(uq, u_side_out.neg, u_side_out.ovf, UN_Q20);
    assign vp_c = sat_uv(vq, v_side_out.neg, v_side_out.ovf, VN_Q20);

    logic                   c1_vld_reg, c2_vld_reg, c3_vld_reg, c4_vld_reg;
    logic signed [UV_W-1:0] c1_up_reg, c2_up_reg, c3_up_reg;
    logic signed [UV_W-1:0] c1_vp_reg, c2_vp_reg, c3_vp_reg, c4_vp_reg;
    logic                   c1_zero_reg, c2_zero_reg, c3_zero_reg, c4_zero_reg;
    logic                   c1_degen_reg, c2_degen_reg, c3_degen_reg, c4_degen_reg;
    logic                   c1_small_reg, c2_small_reg;
    logic [T_W-1:0]         c1_t_reg, c2_t_reg;
    logic [2*T_W-1:0]       c1_tt_reg;
    logic [2*T_W-1:0]       c2_phi_reg, c2_plo_reg;
    logic signed [W_W-1:0]  c2_w_reg, c3_w_reg;
    logic [Y_W-1:0]         c3_y_reg, c4_y_reg;
    logic signed [46:0]     c4_mx_reg;
    logic signed [51:0]     c4_mz_reg;

    // Stage C2 and C3 helpers: the cube of the seed in two half products, and W.
    logic signed [W_W-1:0]   up_w, vp_w;
    logic [3*T_W-1:0]        cube;
    logic [Y_W-1:0]          y_c3;

    assign up_w = W_W'(c1_up_reg);
    assign vp_w = W_W'(c1_vp_reg);
    assign cube = {c2_phi_reg, {T_W{1'b0}}} + (3*T_W)'(c2_plo_reg);
    assign y_c3 = c2_small_reg ? Y_W'(c2_t_reg) : cube[61:40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
            c4_vld_reg <= 1'b0;
        end else if (adv) begin
            c1_vld_reg <= d1_vld;
            c2_vld_reg <= c1_vld_reg;
            c3_vld_reg <= c2_vld_reg;
            c4_vld_reg <= c3_vld_reg;
        end
        if (adv) begin
            c1_up_reg    <= up_c;
            c1_vp_reg    <= vp_c;
            c1_zero_reg  <= u_side_out.zero;
            c1_degen_reg <= ~u_side_out.zero & (vp_c <= 0);
            c1_small_reg <= u_side_out.lin;
            c1_t_reg     <= u_side_out.t;
            c1_tt_reg    <= u_side_out.t * u_side_out.t;

            c2_up_reg    <= c1_up_reg;
            c2_vp_reg    <= c1_vp_reg;
            c2_zero_reg  <= c1_zero_reg;
            c2_degen_reg <= c1_degen_reg;
            c2_small_reg <= c1_small_reg;
            c2_t_reg     <= c1_t_reg;
            c2_phi_reg   <= c1_tt_reg[2*T_W-1:T_W] * c1_t_reg;
            c2_plo_reg   <= c1_tt_reg[T_W-1:0] * c1_t_reg;
            c2_w_reg     <= W_BIAS - ((up_w <<< 1) + up_w) - ((vp_w <<< 4) + (vp_w <<< 2));

            c3_up_reg    <= c2_up_reg;
            c3_vp_reg    <= c2_vp_reg;
            c3_zero_reg  <= c2_zero_reg;
            c3_degen_reg <= c2_degen_reg;
            c3_w_reg     <= c2_w_reg;
            c3_y_reg     <= y_c3;

            c4_vp_reg    <= c3_vp_reg;
            c4_zero_reg  <= c3_zero_reg;
            c4_degen_reg <= c3_degen_reg;
            c4_y_reg     <= c3_y_reg;
            c4_mx_reg    <= $signed({1'b0, c3_y_reg}) * c3_up_reg;
            c4_mz_reg    <= $signed({1'b0, c3_y_reg}) * c3_w_reg;
        end
    end

    // Dividend preparation for the second bank: X = 9 Y u' / (4 v'), Z = Y W / (4 v').
    // A quotient of 2^31 or more saturates, so 31 quotient bits are enough.
    logic signed [50:0]   x9;
    logic [XZD_NUM_W-1:0] x_mag, z_mag;
    logic [XZD_DEN_W-1:0] den4;
    xside_t               x_side_in, x_side_out;
    vside_t               z_side_in, z_side_out;

    assign x9    = (51'(c4_mx_reg) <<< 3) + 51'(c4_mx_reg);
    assign x_mag = x9[50] ? XZD_NUM_W'(-x9) : XZD_NUM_W'(x9);
    assign z_mag = c4_mz_reg[51] ? XZD_NUM_W'(-c4_mz_reg) : XZD_NUM_W'(c4_mz_reg);
    assign den4  = {c4_vp_reg[UV_W-2:0], 2'b00};

    assign x_side_in.y     = c4_y_reg;
    assign x_side_in.neg   = x9[50];
    assign x_side_in.ovf   = XZD_DEN_W'(x_mag[XZD_NUM_W-1:D2_QUO_W]) >= den4;
    assign x_side_in.zero  = c4_zero_reg;
    assign x_side_in.degen = c4_degen_reg;
    assign z_side_in.neg   = c4_mz_reg[51];
    assign z_side_in.ovf   = XZD_DEN_W'(z_mag[XZD_NUM_W-1:D2_QUO_W]) >= den4;

    logic                d2_vld;
    logic [D2_QUO_W-1:0] xq, zq;

    cluv_div_pipe #(
        .NUM_W (XZD_NUM_W),
        .DEN_W (XZD_DEN_W),
        .QUO_W (D2_QUO_W),
        .SIDE_W($bits(xside_t))
    ) u_div_x (
        .aclk   (aclk),
        .aresetn(aresetn),
        .adv    (adv),
        .vld_i  (c4_vld_reg),
        .num_i  (x_mag),
        .den_i  (den4),
        .side_i (x_side_in),
        .vld_o  (d2_vld),
        .quo_o  (xq),
        .side_o (x_side_out)
    );

    cluv_div_pipe #(
        .NUM_W (XZD_NUM_W),
        .DEN_W (XZD_DEN_W),
        .QUO_W (D2_QUO_W),
        .SIDE_W($bits(vside_t))
    ) u_div_z (
        .aclk   (aclk),
        .aresetn(aresetn),
        .adv    (adv),
        .vld_i  (c4_vld_reg),
        .num_i  (z_mag),
        .den_i  (den4),
        .side_i (z_side_in),
        .vld_o  (),
        .quo_o  (zq),
        .side_o (z_side_out)
    );

    // Matrix, rounding and the result register. Zero lightness and a non-positive v'
    // both blank the pixel; only the latter raises degenerate.
    cluv_matrix u_matrix (
        .aclk   (aclk),
        .aresetn(aresetn),
        .adv    (adv),
        .vld_i  (d2_vld),
        .x_i    (sat_xz(xq, x_side_out.neg, x_side_out.ovf)),
        .y_i    (x_side_out.y),
        .z_i    (sat_xz(zq, z_side_out.neg, z_side_out.ovf)),
        .blank_i(x_side_out.zero | x_side_out.degen),
        .degen_i(x_side_out.degen),
        .vld_o  (m_valid),
        .red_o  (m_red),
        .green_o(m_green),
        .blue_o (m_blue),
        .degen_o(m_degenerate)
    );

endmodule

`default_nettype wire

// ----- rtl/cluv_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage, with a sideband.
// Standalone; the caller guarantees that the quotient fits in QUO_W bits.
`default_nettype none

module cluv_div_pipe #(
    parameter int NUM_W  = 37,
    parameter int DEN_W  = 19,
    parameter int QUO_W  = 24,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              vld_i,
    input  wire logic [NUM_W-1:0]  num_i,
    input  wire logic [DEN_W-1:0]  den_i,
    input  wire logic [SIDE_W-1:0] side_i,
    output logic                   vld_o,
    output logic [QUO_W-1:0]       quo_o,
    output logic [SIDE_W-1:0]      side_o
);

    logic              vld_reg  [QUO_W];
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  acc_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic              vld_in;
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  acc_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            // The top dividend bits are already below the divisor.
            assign vld_in  = vld_i;
            assign rem_in  = DEN_W'(num_i[NUM_W-1:QUO_W]);
            assign acc_in  = num_i[QUO_W-1:0];
            assign den_in  = den_i;
            assign side_in = side_i;
        end else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign acc_in  = acc_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, acc_in[QUO_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_in;
            end
            if (adv) begin
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                acc_reg[k]  <= {acc_in[QUO_W-2:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign vld_o  = vld_reg[QUO_W-1];
    assign quo_o  = acc_reg[QUO_W-1];
    assign side_o = side_reg[QUO_W-1];

endmodule

`default_nettype wire

// ----- rtl/cluv_matrix.sv -----
// XYZ to linear RGB matrix, channel rounding and saturation, and the result register.
// Depends on cluv_pkg for the coefficients and the Q0.12 conversion.
`default_nettype none

module cluv_matrix
    import cluv_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   adv,
    input  wire logic                   vld_i,
    input  wire logic signed [XZ_W-1:0] x_i,
    input  wire logic [Y_W-1:0]         y_i,
    input  wire logic signed [XZ_W-1:0] z_i,
    input  wire logic                   blank_i,
    input  wire logic                   degen_i,
    output logic                        vld_o,
    output logic [CH_W-1:0]             red_o,
    output logic [CH_W-1:0]             green_o,
    output logic [CH_W-1:0]             blue_o,
    output logic                        degen_o
);

    logic                    in_vld_reg, prod_vld_reg, sum_vld_reg, out_vld_reg;
    logic signed [XZ_W-1:0]  opnd_reg [3];
    logic                    in_blank_reg, prod_blank_reg, sum_blank_reg;
    logic                    in_degen_reg, prod_degen_reg, sum_degen_reg;
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [CH_W-1:0]         ch_reg [3];
    logic                    degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else if (adv) begin
            in_vld_reg   <= vld_i;
            prod_vld_reg <= in_vld_reg;
            sum_vld_reg  <= prod_vld_reg;
            out_vld_reg  <= sum_vld_reg;
        end
        if (adv) begin
            opnd_reg[0]    <= x_i;
            opnd_reg[1]    <= $signed(XZ_W'(y_i));
            opnd_reg[2]    <= z_i;
            in_blank_reg   <= blank_i;
            in_degen_reg   <= degen_i;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[k][j] <= MAT_Q20[k][j] * opnd_reg[j];
                end
            end
            prod_blank_reg <= in_blank_reg;
            prod_degen_reg <= in_degen_reg;
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= SUM_W'(prod_reg[k][0]) + SUM_W'(prod_reg[k][1])
                              + SUM_W'(prod_reg[k][2]);
            end
            sum_blank_reg  <= prod_blank_reg;
            sum_degen_reg  <= prod_degen_reg;
            for (int k = 0; k < 3; k++) begin
                ch_reg[k] <= sum_blank_reg ? '0 : to_q12(sum_reg[k]);
            end
            degen_reg      <= sum_degen_reg;
        end
    end

    assign vld_o   = out_vld_reg;
    assign red_o   = ch_reg[0];
    assign green_o = ch_reg[1];
    assign blue_o  = ch_reg[2];
    assign degen_o = degen_reg;

endmodule

`default_nettype wire
